// ----- rtl/fbh_pkg.sv -----
// Shared types and constants for the filename bucket hash block.
`timescale 1ns / 1ps
package fbh_pkg;

	localparam int DATA_W = 32;
	localparam int BYTE_W = 8;
	localparam int BASE_W = 5;
	localparam int COUNT_W = 4;
	localparam int CHAR_W = 7;
	localparam int DIGIT_INDEX_W = 3;
	localparam int CFG_INDEX_W = 2;

	localparam int FBH_MAX_DIGITS = 8;

	localparam logic [CHAR_W-1:0] LETTER_A = 7'h41;
	localparam logic [BYTE_W-1:0] SLASH_BYTE = 8'h2F;

	localparam logic [DATA_W-1:0] MULTIPLIER_RST = 32'd31;
	localparam logic [DATA_W-1:0] MODULUS_RST = 32'd1000000007;
	localparam logic [BASE_W-1:0] DIGIT_BASE_RST = 5'd26;
	localparam logic [COUNT_W-1:0] DIGIT_COUNT_RST = 4'd6;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd26;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MULTIPLIER = 2'd0,
		REG_MODULUS = 2'd1,
		REG_DIGIT_BASE = 2'd2,
		REG_DIGIT_COUNT = 2'd3
	} fbh_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fbh_unit_sts_t;

endpackage

// ----- rtl/fbh_if.sv -----
// Valid/ready channel interfaces for path bytes and output digits.
`timescale 1ns / 1ps
interface fbh_byte_if;
	logic valid;
	logic ready;
	logic [7:0] char_byte;
	logic last_char;

	modport source (output valid, output char_byte, output last_char, input ready);
	modport sink (input valid, input char_byte, input last_char, output ready);
endinterface

interface fbh_digit_if;
	logic valid;
	logic ready;
	logic [6:0] digit_char;
	logic [2:0] digit_index;
	logic last_digit;

	modport source (output valid, output digit_char, output digit_index, output last_digit,
		input ready);
	modport sink (input valid, input digit_char, input digit_index, input last_digit,
		output ready);
endinterface

// ----- rtl/fbh_mul.sv -----
// Bit-serial multiply-add unit, product modulo 2^32, one multiplier bit per cycle.
`timescale 1ns / 1ps
module fbh_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fbh_pkg::DATA_W-1:0] op_a,
	input  logic [fbh_pkg::DATA_W-1:0] op_b,
	input  logic [fbh_pkg::DATA_W-1:0] addend,
	output logic [fbh_pkg::DATA_W-1:0] product,
	output fbh_pkg::fbh_unit_sts_t     sts
);
	import fbh_pkg::*;

	localparam int STEP_W = $clog2(DATA_W);

	logic [DATA_W-1:0] a_sh_q;
	logic [DATA_W-1:0] b_sh_q;
	logic [DATA_W-1:0] prod_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= op_a;
			b_sh_q <= op_b;
			prod_q <= addend;
		end else if (busy_q) begin
			if (b_sh_q[0]) begin
				prod_q <= prod_q + a_sh_q;
			end
			a_sh_q <= {a_sh_q[DATA_W-2:0], 1'b0};
			b_sh_q <= {1'b0, b_sh_q[DATA_W-1:1]};
		end
	end

	assign product = prod_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// ----- rtl/fbh_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fbh_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fbh_pkg::DATA_W-1:0] dividend,
	input  logic [fbh_pkg::DATA_W-1:0] divisor,
	output logic [fbh_pkg::DATA_W-1:0] quotient,
	output logic [fbh_pkg::DATA_W-1:0] remainder,
	output fbh_pkg::fbh_unit_sts_t     sts
);
	import fbh_pkg::*;

	localparam int STEP_W = $clog2(DATA_W);

	logic [DATA_W-1:0] quot_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvsr_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [DATA_W:0] trial;
	logic [DATA_W:0] diff;
	logic fits;

	always_comb begin
		trial = {rem_q, quot_q[DATA_W-1]};
		diff = trial - {1'b0, dvsr_q};
		fits = trial >= {1'b0, dvsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quot_q <= {quot_q[DATA_W-2:0], fits};
		end
	end

	assign quotient = quot_q;
	assign remainder = rem_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// ----- rtl/filename_bucket_hash.sv -----
// Top level of the filename bucket hash: config registers, sequencer, output register.
`timescale 1ns / 1ps
// Path bytes arrive on in_ch (char_byte, last_char) with valid/ready; letter
// digits leave on out_ch (digit_char, digit_index, last_digit). Registers are
// written through cfg_we / cfg_index / cfg_wdata; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// One byte is taken at a time; in_ch.ready is high only between bytes.
// A slash byte clears the accumulator without the arithmetic units. Any other
// byte runs through the bit-serial multiply-add unit and then the restoring
// divider for the modulus reduction (the divider is skipped when the modulus
// is zero). On the last byte each digit is produced by the same divider and
// the output register, then waits in the output register until taken.
// A stalled receiver holds the digit and the sequencer; no input is taken
// until the last digit is delivered. Reset clears the accumulator, loads the
// default register values and leaves both channels idle.
module filename_bucket_hash #(
	parameter int MAX_DIGITS = fbh_pkg::FBH_MAX_DIGITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fbh_byte_if.sink                        in_ch,
	fbh_digit_if.source                     out_ch,
	input  logic                            cfg_we,
	input  logic [fbh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fbh_pkg::DATA_W-1:0]      cfg_wdata
);
	import fbh_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_MOD  = 5'b00100,
		ST_DIG  = 5'b01000,
		ST_OUT  = 5'b10000
	} fbh_state_t;

	fbh_state_t state_q;
	logic [DATA_W-1:0] multiplier_q;
	logic [DATA_W-1:0] modulus_q;
	logic [BASE_W-1:0] digit_base_q;
	logic [COUNT_W-1:0] digit_count_q;
	logic [DATA_W-1:0] acc_q;
	logic last_q;
	logic [CNT_W-1:0] dig_q;
	logic [CHAR_W-1:0] digit_char_q;
	logic [DIGIT_INDEX_W-1:0] digit_index_q;
	logic last_digit_q;

	logic [BASE_W-1:0] base_eff;
	logic [CNT_W-1:0] count_eff;
	logic in_acc;
	logic out_acc;
	logic is_slash;
	logic mod_zero;
	logic [DATA_W-1:0] sext_byte;

	logic mul_start;
	logic [DATA_W-1:0] mul_prod;
	fbh_unit_sts_t mul_sts;
	logic div_start;
	logic [DATA_W-1:0] div_dividend;
	logic [DATA_W-1:0] div_divisor;
	logic [DATA_W-1:0] div_quot;
	logic [DATA_W-1:0] div_rem;
	fbh_unit_sts_t div_sts;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_acc = out_ch.valid && out_ch.ready;
	assign out_ch.digit_char = digit_char_q;
	assign out_ch.digit_index = digit_index_q;
	assign out_ch.last_digit = last_digit_q;

	assign is_slash = (in_ch.char_byte == SLASH_BYTE);
	assign mod_zero = (modulus_q == '0);
	assign sext_byte = {{(DATA_W - BYTE_W){in_ch.char_byte[BYTE_W-1]}}, in_ch.char_byte};

	always_comb begin
		priority if (digit_base_q < BASE_MIN) begin
			base_eff = BASE_MIN;
		end else if (digit_base_q > BASE_MAX) begin
			base_eff = BASE_MAX;
		end else begin
			base_eff = digit_base_q;
		end
		priority if (DATA_W'(digit_count_q) > DATA_W'(MAX_DIGITS)) begin
			count_eff = CNT_W'(MAX_DIGITS);
		end else if (digit_count_q == '0) begin
			count_eff = CNT_W'(1);
		end else begin
			count_eff = CNT_W'(digit_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multiplier_q <= MULTIPLIER_RST;
			modulus_q <= MODULUS_RST;
			digit_base_q <= DIGIT_BASE_RST;
			digit_count_q <= DIGIT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (fbh_reg_t'(cfg_index))
				REG_MULTIPLIER: multiplier_q <= cfg_wdata;
				REG_MODULUS: modulus_q <= cfg_wdata;
				REG_DIGIT_BASE: digit_base_q <= cfg_wdata[BASE_W-1:0];
				REG_DIGIT_COUNT: digit_count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign mul_start = in_acc && !is_slash;

	always_comb begin
		div_start = 1'b0;
		div_dividend = acc_q;
		div_divisor = DATA_W'(base_eff);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_slash && in_ch.last_char) begin
					div_start = 1'b1;
					div_dividend = '0;
				end
			end
			ST_MUL: begin
				if (mul_sts.done) begin
					div_dividend = mul_prod;
					if (!mod_zero) begin
						div_start = 1'b1;
						div_divisor = modulus_q;
					end else begin
						div_start = last_q;
					end
				end
			end
			ST_MOD: begin
				if (div_sts.done && last_q) begin
					div_start = 1'b1;
					div_dividend = div_rem;
				end
			end
			ST_OUT: begin
				div_start = out_acc && !last_digit_q;
			end
			ST_DIG: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q <= '0;
			last_q <= 1'b0;
			dig_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						last_q <= in_ch.last_char;
						if (!is_slash) begin
							state_q <= ST_MUL;
						end else begin
							acc_q <= '0;
							if (in_ch.last_char) begin
								state_q <= ST_DIG;
							end
						end
					end
				end
				ST_MUL: begin
					if (mul_sts.done) begin
						if (!mod_zero) begin
							state_q <= ST_MOD;
						end else begin
							acc_q <= mul_prod;
							state_q <= last_q ? ST_DIG : ST_IDLE;
						end
					end
				end
				ST_MOD: begin
					if (div_sts.done) begin
						acc_q <= div_rem;
						state_q <= last_q ? ST_DIG : ST_IDLE;
					end
				end
				ST_DIG: begin
					if (div_sts.done) begin
						acc_q <= div_quot;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (last_digit_q) begin
							acc_q <= '0;
							dig_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							dig_q <= dig_q + 1'b1;
							state_q <= ST_DIG;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIG && div_sts.done) begin
			digit_char_q <= LETTER_A + CHAR_W'(div_rem[BASE_W-1:0]);
			digit_index_q <= DIGIT_INDEX_W'(dig_q);
			last_digit_q <= (CNT_W'(dig_q + 1'b1) == count_eff);
		end
	end

	fbh_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (acc_q),
		.op_b    (multiplier_q),
		.addend  (sext_byte),
		.product (mul_prod),
		.sts     (mul_sts)
	);

	fbh_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quot),
		.remainder (div_rem),
		.sts       (div_sts)
	);

endmodule

// ----- rtl/fbh_chk.sv -----
// Port-level checker for the filename bucket hash, bound to the top level.
`timescale 1ns / 1ps
module fbh_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last_char,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_digit_char,
	input logic [2:0] out_digit_index,
	input logic       out_last_digit
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
			&& $stable(out_digit_index) && $stable(out_last_digit))
		else $error("stalled digit transaction changed");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a digit is pending");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_digit_char >= 7'h41 && out_digit_char <= 7'h5A)
		else $error("digit letter out of range");

	a_quiet_after_mid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_last_char |=> !out_valid)
		else $error("digit emitted for a byte not marked last");

	a_end_of_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last_digit |=> !out_valid)
		else $error("digit emitted after the last digit of a run");

endmodule

bind filename_bucket_hash fbh_chk u_fbh_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.in_last_char    (in_ch.last_char),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_digit_char  (out_ch.digit_char),
	.out_digit_index (out_ch.digit_index),
	.out_last_digit  (out_ch.last_digit)
);

// ----- tb/filename_bucket_hash_tb.sv -----
// Self-checking testbench for filename_bucket_hash: shadow hash model, random paths, stalls.
`timescale 1ns / 1ps
module filename_bucket_hash_tb;
	import fbh_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic              fin;
	} path_byte_t;

	typedef struct packed {
		logic [CHAR_W-1:0]        ch;
		logic [DIGIT_INDEX_W-1:0] idx;
		logic                     fin;
	} digit_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_wdata;

	fbh_byte_if byte_ch ();
	fbh_digit_if digit_ch ();

	filename_bucket_hash u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (byte_ch),
		.out_ch    (digit_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	path_byte_t path_bytes[$];
	digit_t digits_due[$];

	logic [DATA_W-1:0] mult_shadow = MULTIPLIER_RST;
	logic [DATA_W-1:0] mod_shadow = MODULUS_RST;
	logic [BASE_W-1:0] base_shadow = DIGIT_BASE_RST;
	logic [COUNT_W-1:0] count_shadow = DIGIT_COUNT_RST;
	logic [DATA_W-1:0] name_hash = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	logic in_fire = 1'b0;

	always #4 clk = ~clk;

	function automatic void hash_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic [DATA_W-1:0] v;
		int base;
		int count;
		digit_t d;
		if (b == SLASH_BYTE) begin
			name_hash = '0;
		end else begin
			v = name_hash * mult_shadow + {{(DATA_W-BYTE_W){b[BYTE_W-1]}}, b};
			if (mod_shadow != '0)
				v = v % mod_shadow;
			name_hash = v;
		end
		if (fin) begin
			base = base_shadow;
			if (base < BASE_MIN)
				base = BASE_MIN;
			if (base > BASE_MAX)
				base = BASE_MAX;
			count = count_shadow;
			if (count < 1)
				count = 1;
			if (count > FBH_MAX_DIGITS)
				count = FBH_MAX_DIGITS;
			v = name_hash;
			for (int i = 0; i < count; i++) begin
				d.ch = LETTER_A + CHAR_W'(v % base);
				d.idx = DIGIT_INDEX_W'(i);
				d.fin = (i == count - 1);
				digits_due = {digits_due, d};
				v = v / base;
			end
			name_hash = '0;
		end
	endfunction

	// monitor: check digits, then predict from the accepted byte
	always @(posedge clk) begin
		digit_t got;
		digit_t want;
		in_fire <= arst_n && byte_ch.valid && byte_ch.ready;
		if (arst_n && digit_ch.valid && digit_ch.ready) begin
			got.ch = digit_ch.digit_char;
			got.idx = digit_ch.digit_index;
			got.fin = digit_ch.last_digit;
			if (digits_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected digit: char=%h index=%0d last=%b",
						got.ch, got.idx, got.fin);
			end else begin
				want = digits_due.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("digit mismatch: exp %h/%0d/%b got %h/%0d/%b",
							want.ch, want.idx, want.fin, got.ch, got.idx, got.fin);
				end
			end
		end
		if (arst_n && byte_ch.valid && byte_ch.ready)
			hash_byte(byte_ch.char_byte, byte_ch.last_char);
	end

	// driver: advance on each accepted transaction, idle at random
	always @(negedge clk) begin
		path_byte_t item;
		if (!byte_ch.valid || in_fire) begin
			if (path_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item = path_bytes.pop_front();
				byte_ch.valid <= 1'b1;
				byte_ch.char_byte <= item.ch;
				byte_ch.last_char <= item.fin;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
		digit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic fin);
		path_byte_t item;
		item.ch = b;
		item.fin = fin;
		path_bytes = {path_bytes, item};
	endfunction

	function automatic int push_path();
		int n;
		logic [BYTE_W-1:0] b;
		if ($urandom_range(7) == 0) begin
			push_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
			return 1;
		end
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			b = ($urandom_range(4) == 0) ? SLASH_BYTE : BYTE_W'($urandom_range(255));
			push_byte(b, i == n - 1);
		end
		return n;
	endfunction

	task automatic write_reg(input fbh_reg_t idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_MULTIPLIER: mult_shadow = data;
			REG_MODULUS: mod_shadow = data;
			REG_DIGIT_BASE: base_shadow = data[BASE_W-1:0];
			REG_DIGIT_COUNT: count_shadow = data[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (path_bytes.size() != 0 || byte_ch.valid || digits_due.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic run_phase(input logic [DATA_W-1:0] mult, input logic [DATA_W-1:0] md,
		input logic [BASE_W-1:0] base, input logic [COUNT_W-1:0] count,
		input int send_pct, input int recv_pct, input int n_items, input bit mid_pause);
		int queued;
		bit paused;
		queued = 0;
		paused = 0;
		write_reg(REG_MULTIPLIER, mult);
		write_reg(REG_MODULUS, md);
		write_reg(REG_DIGIT_BASE, DATA_W'(base));
		write_reg(REG_DIGIT_COUNT, DATA_W'(count));
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (queued < n_items) begin
			if (mid_pause && !paused && queued >= n_items / 2) begin
				wait_idle();
				paused = 1;
			end
			queued += push_path();
		end
		wait_idle();
	endtask

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MULTIPLIER;
		cfg_wdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.char_byte = '0;
		byte_ch.last_char = 1'b0;
		digit_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// reset values, then short paths hitting the byte extremes
		push_byte(8'h61, 1'b1);
		push_byte(SLASH_BYTE, 1'b0);
		push_byte(8'h78, 1'b0);
		push_byte(SLASH_BYTE, 1'b0);
		push_byte(8'h79, 1'b0);
		push_byte(8'h7A, 1'b1);
		push_byte(8'h41, 1'b0);
		push_byte(SLASH_BYTE, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		wait_idle();

		// modulus zero, wide multiplier, base and count above range
		write_reg(REG_MODULUS, 32'd0);
		write_reg(REG_MULTIPLIER, 32'hFFFF_FFFF);
		write_reg(REG_DIGIT_BASE, 32'd31);
		write_reg(REG_DIGIT_COUNT, 32'd15);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b1);
		push_byte(SLASH_BYTE, 1'b1);
		wait_idle();

		// base and count below range
		write_reg(REG_DIGIT_BASE, 32'd1);
		write_reg(REG_DIGIT_COUNT, 32'd0);
		push_byte(8'h55, 1'b0);
		push_byte(8'hAA, 1'b1);
		push_byte(8'h2E, 1'b1);
		wait_idle();

		run_phase(32'd31, 32'd1000000007, 5'd26, 4'd6, 0, 0, 80, 1'b0);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2, 4'd8, 88, 0, 70, 1'b0);
		run_phase($urandom, 32'd0, 5'd31, 4'd15, 0, 88, 70, 1'b0);
		run_phase(32'd0, 32'd1, 5'd0, 4'd0, 25, 25, 60, 1'b1);
		run_phase($urandom, $urandom, BASE_W'($urandom_range(31)),
			COUNT_W'($urandom_range(15)), 25, 25, 70, 1'b1);
		run_phase(32'd1, 32'd97, 5'd26, 4'd1, 0, 0, 70, 1'b0);

		if (mismatch_count == 0 && digits_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/fbh_pkg.sv
rtl/fbh_if.sv
rtl/fbh_mul.sv
rtl/fbh_div.sv
rtl/filename_bucket_hash.sv
rtl/fbh_chk.sv
tb/filename_bucket_hash_tb.sv
